/* rtl/dtzp_pkg.sv */
// Shared types, character codes and field tables for the date/time/zone parser.
// No dependencies; used by dtzp_step and the top level.

package dtzp_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [13:0] ACC_MAX         = 14'd16383;
    localparam logic [13:0] ZONE_LIMIT_STD  = 14'd48;
    localparam logic [13:0] ZONE_LIMIT_WIDE = 14'd96;
    localparam logic [16:0] SEC_PER_QUARTER = 17'd900;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_DIGIT_YEAR = 2'd0;
    localparam logic [1:0] CFG_WIDE_ZONE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ZONE_OPTIONAL   = 2'd2;

    typedef enum logic [2:0] {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_ZONE
    } t_field;

    typedef struct packed {
        logic four_digit_year;
        logic wide_zone_limit;
        logic zone_optional;
    } t_cfg;

    typedef struct packed {
        t_field      field;
        logic [13:0] acc;
        logic        stopped;
        logic        err;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        zone_neg;
        logic [1:0]  zone_cnt;
        logic [6:0]  zone_pair;
    } t_state;

    typedef struct packed {
        logic        ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        zone_present;
        logic        zone_neg;
        logic [6:0]  zone_quarters;
        logic [7:0]  stored_zone;
    } t_result;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* rtl/dtzp_step.sv */
// Per-character next-state and record result logic of the date/time/zone parser.
// Depends on dtzp_pkg.

module dtzp_step (
    input  dtzp_pkg::t_state  i_state,
    input  dtzp_pkg::t_cfg    i_cfg,
    input  logic [7:0]        i_char,
    input  logic              i_part,
    input  logic              i_last,
    output dtzp_pkg::t_state  o_state,
    output dtzp_pkg::t_result o_result
);

    function automatic dtzp_pkg::t_state take_digit(input dtzp_pkg::t_state s,
                                                    input logic dig,
                                                    input logic [3:0] dval);
        logic [17:0] sum;
        sum = {4'b0, s.acc} * 18'd10 + {14'b0, dval};
        if (!s.stopped) begin
            if (!dig) begin
                s.stopped = 1'b1;
            end else if (sum > {4'b0, dtzp_pkg::ACC_MAX}) begin
                s.acc = dtzp_pkg::ACC_MAX;
            end else begin
                s.acc = sum[13:0];
            end
        end
        return s;
    endfunction

    function automatic dtzp_pkg::t_state next_field(input dtzp_pkg::t_state s);
        s.field   = dtzp_pkg::t_field'(s.field + 3'd1);
        s.acc     = '0;
        s.stopped = 1'b0;
        return s;
    endfunction

    // Check the open field against its range and latch it; the zone is checked at record end.
    function automatic dtzp_pkg::t_state close_field(input dtzp_pkg::t_state s,
                                                     input dtzp_pkg::t_cfg cfg);
        logic [4:0] len;
        // latched years are 1970..2099, where divisible by four is the full leap rule
        len = dtzp_pkg::month_days(s.month, s.year[1:0] == 2'b00);
        unique case (s.field)
            dtzp_pkg::FLD_YEAR: begin
                if (cfg.four_digit_year) begin
                    if (s.acc >= 14'd2000 && s.acc <= 14'd2099) s.year = s.acc[11:0];
                    else s.err = 1'b1;
                end else if (s.acc < 14'd70) begin
                    s.year = 12'd2000 + {5'b0, s.acc[6:0]};
                end else if (s.acc <= 14'd99) begin
                    s.year = 12'd1900 + {5'b0, s.acc[6:0]};
                end else begin
                    s.err = 1'b1;
                end
            end
            dtzp_pkg::FLD_MONTH: begin
                if (s.acc >= 14'd1 && s.acc <= 14'd12) s.month = s.acc[3:0];
                else s.err = 1'b1;
            end
            dtzp_pkg::FLD_DAY: begin
                if (s.month < 4'd1 || s.month > 4'd12) s.err = 1'b1;
                else if (s.acc >= 14'd1 && s.acc <= {9'b0, len}) s.day = s.acc[4:0];
                else s.err = 1'b1;
            end
            dtzp_pkg::FLD_HOUR: begin
                if (s.acc < 14'd24) s.hour = s.acc[4:0];
                else s.err = 1'b1;
            end
            dtzp_pkg::FLD_MINUTE: begin
                if (s.acc < 14'd60) s.minute = s.acc[5:0];
                else s.err = 1'b1;
            end
            dtzp_pkg::FLD_SECOND: begin
                if (s.acc < 14'd60) s.second = s.acc[5:0];
                else s.err = 1'b1;
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    logic             w_dig;
    logic [3:0]       w_dval;
    logic             w_sign;
    logic [13:0]      w_limit;
    logic             w_present;
    logic [6:0]       w_quarters;
    dtzp_pkg::t_state w_s;

    assign w_dig   = (i_char >= dtzp_pkg::CH_ZERO) && (i_char <= dtzp_pkg::CH_NINE);
    assign w_dval  = 4'(i_char - dtzp_pkg::CH_ZERO);
    assign w_sign  = (i_char == dtzp_pkg::CH_PLUS) || (i_char == dtzp_pkg::CH_MINUS);
    assign w_limit = i_cfg.wide_zone_limit ? dtzp_pkg::ZONE_LIMIT_WIDE : dtzp_pkg::ZONE_LIMIT_STD;

    always_comb begin
        w_s        = i_state;
        w_present  = 1'b0;
        w_quarters = '0;
        o_result   = '0;

        if (!i_part) begin
            if (w_s.field >= dtzp_pkg::FLD_HOUR) begin
                w_s.err = 1'b1;
            end else if (i_char == dtzp_pkg::CH_SLASH && w_s.field < dtzp_pkg::FLD_DAY) begin
                w_s = next_field(close_field(w_s, i_cfg));
            end else begin
                w_s = take_digit(w_s, w_dig, w_dval);
            end
        end else begin
            // first time character closes the date
            if (w_s.field < dtzp_pkg::FLD_HOUR) begin
                if (w_s.field < dtzp_pkg::FLD_DAY) w_s.err = 1'b1;
                else w_s = close_field(w_s, i_cfg);
                w_s.field   = dtzp_pkg::FLD_HOUR;
                w_s.acc     = '0;
                w_s.stopped = 1'b0;
            end
            if (w_s.field < dtzp_pkg::FLD_SECOND && i_char == dtzp_pkg::CH_COLON) begin
                w_s = next_field(close_field(w_s, i_cfg));
            end else if (w_s.field == dtzp_pkg::FLD_SECOND && w_sign) begin
                w_s           = next_field(close_field(w_s, i_cfg));
                w_s.zone_neg  = (i_char == dtzp_pkg::CH_MINUS);
                w_s.zone_cnt  = '0;
                w_s.zone_pair = '0;
            end else if (w_s.field == dtzp_pkg::FLD_ZONE) begin
                if (!w_s.stopped && w_dig && w_s.zone_cnt < 2'd2) begin
                    w_s.zone_pair = 7'(w_s.zone_pair * 7'd10 + {3'b0, w_dval});
                end
                w_s = take_digit(w_s, w_dig, w_dval);
                if (w_s.zone_cnt < 2'd2) w_s.zone_cnt = w_s.zone_cnt + 2'd1;
            end else begin
                w_s = take_digit(w_s, w_dig, w_dval);
            end
        end

        if (i_last) begin
            if (w_s.field < dtzp_pkg::FLD_SECOND) begin
                w_s.err = 1'b1;
            end else if (w_s.field == dtzp_pkg::FLD_SECOND) begin
                w_s = close_field(w_s, i_cfg);
                if (!i_cfg.zone_optional) w_s.err = 1'b1;
            end else begin
                if (w_s.acc > w_limit) w_s.err = 1'b1;
                else w_quarters = w_s.acc[6:0];
                w_present = 1'b1;
            end
        end

        if (!w_s.err) begin
            o_result.ok            = 1'b1;
            o_result.year          = w_s.year;
            o_result.month         = w_s.month;
            o_result.day           = w_s.day;
            o_result.hour          = w_s.hour;
            o_result.minute        = w_s.minute;
            o_result.second        = w_s.second;
            o_result.zone_present  = w_present;
            o_result.zone_neg      = w_present & w_s.zone_neg;
            o_result.zone_quarters = w_quarters;
            if (w_present) begin
                o_result.stored_zone = w_s.zone_neg ? 8'(-{1'b0, w_s.zone_pair})
                                                    : {1'b0, w_s.zone_pair};
            end
        end

        // a finished record starts the next one from the cleared state
        o_state = i_last ? '0 : w_s;
    end

endmodule

/* rtl/date_time_zone_string_parser.sv */
// Top level of the date/time/zone string parser: state, config and result registers.
// Depends on dtzp_pkg and dtzp_step.
//
// Usage: feed the date string "yy/mm/dd" or, with four-digit years, "yyyy/mm/dd"
// (i_part = 0) and then the time string "hh:mm:ss+zz" (i_part = 1), one character
// per word on the input channel (i_in_valid / o_in_ready). i_last marks the final
// character; that word produces one result word on the output channel
// (o_out_valid / i_out_ready), all other words produce none. o_ok = 0 flags a
// format or range error and zeroes every other result field.
// Throughput is one character per cycle while o_in_ready is high: each character
// updates the parse state through combinational logic. o_out_valid rises in the
// cycle after the last character is accepted, from the result register.
// While a result waits for i_out_ready the block takes no characters; it takes
// them again in the same cycle the result is taken, so a stalled receiver holds
// o_in_ready low only while the result register is full and not being drained.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write it only while no record is in flight, which the block leaves unchecked; index 3 is ignored.
// Reset clears the parse state, the configuration and the result valid flag.

module date_time_zone_string_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [0:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_part,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output logic [11:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic [4:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second,
    output logic               o_zone_present,
    output logic signed [17:0] o_zone_seconds,
    output logic signed [7:0]  o_stored_zone
);

    dtzp_pkg::t_state  r_state;
    dtzp_pkg::t_state  n_state;
    dtzp_pkg::t_cfg    r_cfg;
    dtzp_pkg::t_result r_out;
    dtzp_pkg::t_result n_out;
    logic              r_out_valid;
    logic              w_in_acc;
    logic [16:0]       w_zone_mag;
    logic [17:0]       w_zone_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    dtzp_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_char   (i_char_code),
        .i_part   (i_part),
        .i_last   (i_last),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dtzp_pkg::CFG_FOUR_DIGIT_YEAR: r_cfg.four_digit_year <= i_cfg_data[0];
                    dtzp_pkg::CFG_WIDE_ZONE_LIMIT: r_cfg.wide_zone_limit <= i_cfg_data[0];
                    dtzp_pkg::CFG_ZONE_OPTIONAL:   r_cfg.zone_optional   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                r_state <= n_state;
            end
            if (w_in_acc && i_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last) begin
            r_out <= n_out;
        end
    end

    // quarter hours to seconds, signed
    assign w_zone_mag = {10'b0, r_out.zone_quarters} * dtzp_pkg::SEC_PER_QUARTER;
    assign w_zone_ext = {1'b0, w_zone_mag};

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out.ok;
    assign o_year         = r_out.year;
    assign o_month        = r_out.month;
    assign o_day          = r_out.day;
    assign o_hour         = r_out.hour;
    assign o_minute       = r_out.minute;
    assign o_second       = r_out.second;
    assign o_zone_present = r_out.zone_present;
    assign o_zone_seconds = r_out.zone_neg ? 18'(-w_zone_ext) : w_zone_ext;
    assign o_stored_zone  = r_out.stored_zone;

endmodule

/* rtl/dtzp_chk.sv */
// Port-level assertions for the date/time/zone string parser, bound to the top level.
// Depends on date_time_zone_string_parser's port list.

module dtzp_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               i_last,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               o_ok,
    input  logic [11:0]        o_year,
    input  logic [3:0]         o_month,
    input  logic [4:0]         o_day,
    input  logic [4:0]         o_hour,
    input  logic [5:0]         o_minute,
    input  logic [5:0]         o_second,
    input  logic               o_zone_present,
    input  logic signed [17:0] o_zone_seconds,
    input  logic signed [7:0]  o_stored_zone
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_year) && $stable(o_ok))
        else $error("result word changed while stalled");

    // the last character always yields a result word next cycle
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> o_out_valid)
        else $error("no result after last character");

    // an error record carries zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_year == 12'd0 && o_month == 4'd0 && o_day == 5'd0 &&
        o_hour == 5'd0 && o_minute == 6'd0 && o_second == 6'd0 && !o_zone_present &&
        o_zone_seconds == 18'sd0 && o_stored_zone == 8'sd0)
        else $error("error record with nonzero fields");

    // a valid record is in range
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ok |-> o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 &&
        o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60 &&
        o_year >= 12'd1970 && o_year <= 12'd2099)
        else $error("valid record out of range");

    // no zone suffix means no zone value
    a_no_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zone_present |-> o_zone_seconds == 18'sd0 && o_stored_zone == 8'sd0)
        else $error("zone value without zone suffix");

endmodule

bind date_time_zone_string_parser dtzp_chk u_dtzp_chk (.*);
